// File: src/sfr_pkg.sv
// Shared constants and types for the sensor frame receiver.
`default_nettype none
package sfr_pkg;
    localparam int BUFFER_BYTES = 256;
    localparam int CNT_W = $clog2(BUFFER_BYTES);

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    localparam int FRAME_MIN = 38;
    localparam int SUM_SPAN = 36;
    localparam int CHK_HI_POS = 36;
    localparam int CHK_LO_POS = 37;
    localparam int PAYLOAD_LAST_POS = 30;

    // bytes 1..30 are kept as 15 big-endian words
    localparam int WORD_CNT = 15;
    localparam int CO2_WORD = 4;

    localparam logic [3:0] FIELD_BATT_STATUS = 4'd7;
    localparam logic [3:0] FIELD_BATT_LEVEL = 4'd8;
    localparam logic [3:0] FIELD_LAST = 4'd15;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [15:0] word_t;
endpackage
`default_nettype wire

// File: src/sensor_frame_receiver_unit.sv
// Sensor frame receiver: byte-wise frame assembly, validation and field burst.
//
// Takes one serial byte per cycle on rx_byte. Bytes are dropped until 0xAA opens
// a frame; the frame closes on LF right after CR (3 or more bytes stored) and is
// checked for trimmed length >= 38, the 16-bit sum of bytes 0..35 against bytes
// 36..37, and a nonzero CO2 word. A good frame produces 16 output transactions
// (field_index 0..15, last_field on 15), one per cycle when out_stall is low.
// While those fields are moved from the frame word store into the output
// register, in_stall is high, and the stall lasts longer while out_stall holds
// the output. Otherwise one byte per cycle.
`default_nettype none
module sensor_frame_receiver_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire  [7:0]          rx_byte,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [3:0]          field_index,
    output sfr_pkg::word_t      field_value,
    output logic                last_field
);
    import sfr_pkg::*;

    count_t count_reg, count_next;
    count_t clen_reg, clen_next;
    word_t  sum_reg, sum_next;
    word_t  chk_reg, chk_next;
    logic   prev_cr_reg, prev_cr_next;
    word_t  store_reg [WORD_CNT];

    logic       burst_reg, burst_next;
    logic [3:0] fcnt_reg, fcnt_next;

    logic       ov_reg, ov_next;
    logic [3:0] idx_reg;
    word_t      val_reg;
    logic       last_reg;

    logic       accept;
    logic       store_byte;
    logic       in_payload;
    count_t     pos_m1;
    logic [3:0] wr_word;
    logic       frame_end;
    logic       frame_good;
    logic       load;
    logic [3:0] rd_word;
    word_t      rd_data;
    word_t      fld_value;

    assign accept = in_valid && !in_stall;
    assign in_stall = burst_reg;

    // byte handling
    assign pos_m1 = count_reg - count_t'(1);
    assign wr_word = pos_m1[4:1];
    assign in_payload = (count_reg != '0) && (count_reg <= count_t'(PAYLOAD_LAST_POS));
    assign frame_end = (rx_byte == LF_BYTE) && (count_reg >= count_t'(2)) && prev_cr_reg;
    // the closing LF sits past byte 37, so the checks see registered state only
    assign frame_good = (clen_reg >= count_t'(FRAME_MIN)) && (sum_reg == chk_reg)
                        && (store_reg[CO2_WORD] != '0);

    always_comb
    begin
        count_next = count_reg;
        clen_next = clen_reg;
        sum_next = sum_reg;
        chk_next = chk_reg;
        prev_cr_next = prev_cr_reg;
        store_byte = 1'b0;
        burst_next = burst_reg;
        fcnt_next = fcnt_reg;
        if (accept && !(count_reg == '0 && rx_byte != START_BYTE))
        begin
            if (count_reg == count_t'(BUFFER_BYTES - 1))
            begin
                count_next = '0;
                clen_next = '0;
                sum_next = '0;
                prev_cr_next = 1'b0;
            end
            else if (frame_end)
            begin
                count_next = '0;
                clen_next = '0;
                sum_next = '0;
                prev_cr_next = 1'b0;
                if (frame_good)
                begin
                    burst_next = 1'b1;
                    fcnt_next = '0;
                end
            end
            else
            begin
                store_byte = in_payload;
                count_next = count_reg + count_t'(1);
                if (rx_byte != CR_BYTE && rx_byte != LF_BYTE)
                    clen_next = count_reg + count_t'(1);
                if (count_reg < count_t'(SUM_SPAN))
                    sum_next = sum_reg + {8'h00, rx_byte};
                if (count_reg == count_t'(CHK_HI_POS))
                    chk_next = {rx_byte, chk_reg[7:0]};
                if (count_reg == count_t'(CHK_LO_POS))
                    chk_next = {chk_reg[15:8], rx_byte};
                prev_cr_next = (rx_byte == CR_BYTE);
            end
        end
        if (load)
        begin
            fcnt_next = fcnt_reg + 4'd1;
            if (fcnt_reg == FIELD_LAST)
                burst_next = 1'b0;
        end
    end

    // field burst into the output register
    assign load = burst_reg && (!ov_reg || !out_stall);
    assign rd_word = (fcnt_reg <= FIELD_BATT_STATUS) ? fcnt_reg : fcnt_reg - 4'd1;
    assign rd_data = store_reg[rd_word];

    always_comb
    begin
        if (fcnt_reg == FIELD_BATT_STATUS)
            fld_value = {8'h00, rd_data[15:8]};
        else if (fcnt_reg == FIELD_BATT_LEVEL)
            fld_value = {8'h00, rd_data[7:0]};
        else
            fld_value = rd_data;
    end

    always_comb
    begin
        if (load)
            ov_next = 1'b1;
        else if (!out_stall)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clen_reg <= '0;
            sum_reg <= '0;
            prev_cr_reg <= 1'b0;
            burst_reg <= 1'b0;
            fcnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            clen_reg <= clen_next;
            sum_reg <= sum_next;
            prev_cr_reg <= prev_cr_next;
            burst_reg <= burst_next;
            fcnt_reg <= fcnt_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg <= chk_next;
        if (store_byte)
        begin
            if (!pos_m1[0])
                store_reg[wr_word] <= {rx_byte, store_reg[wr_word][7:0]};
            else
                store_reg[wr_word] <= {store_reg[wr_word][15:8], rx_byte};
        end
        if (load)
        begin
            idx_reg <= fcnt_reg;
            val_reg <= fld_value;
            last_reg <= (fcnt_reg == FIELD_LAST);
        end
    end

    assign out_valid = ov_reg;
    assign field_index = idx_reg;
    assign field_value = val_reg;
    assign last_field = last_reg;
endmodule
`default_nettype wire

// File: src/sfr_checker.sv
// Port-level checks for the sensor frame receiver, bound to the top level.
`default_nettype none
module sfr_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input wire [7:0]           rx_byte,
    input wire                 out_valid,
    input wire                 out_stall,
    input wire [3:0]           field_index,
    input wire sfr_pkg::word_t field_value,
    input wire                 last_field
);
    import sfr_pkg::*;

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte))
        else $error("input changed while stalled");

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(field_index)
            && $stable(field_value) && $stable(last_field))
        else $error("output changed while stalled");

    // input stays stalled until the last field has reached the output
    a_stall_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_field |-> in_stall)
        else $error("input open during field burst");

    // fields of one frame follow back to back
    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_field |=> out_valid)
        else $error("gap inside field burst");

    // input reopens only with the final field on the output
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid && last_field && field_index == FIELD_LAST)
        else $error("input reopened before last field");
endmodule

bind sensor_frame_receiver_unit sfr_checker u_sfr_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .field_index(field_index),
    .field_value(field_value),
    .last_field(last_field)
);
`default_nettype wire

// File: tb/sv/sensor_frame_receiver_unit_test.sv
// Self-checking testbench for the sensor frame receiver unit.
`timescale 1ns / 1ps

module sensor_frame_receiver_unit_test;
    import sfr_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int CO2_HI_POS = 1 + 2 * CO2_WORD;

    typedef struct packed {
        logic [3:0] idx;
        word_t      value;
        logic       last;
    } field_t;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
    typedef enum {TRAIL_CRLF, TRAIL_CR_CRLF, TRAIL_LF_CRLF} trail_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [3:0] field_index;
    word_t      field_value;
    logic       last_field;

    // expected field transactions, oldest first
    field_t pending_fields[$];
    // bytes of the frame about to be transmitted
    logic [7:0] tx_frame[$];

    // receiver mirror
    int         open_len;
    logic [7:0] open_bytes[FRAME_MIN];
    word_t      open_sum;
    int         open_trimmed;
    logic       open_last_cr;

    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int error_count = 0;
    int framed_byte_count = 0;
    int field_count = 0;

    sensor_frame_receiver_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .field_index (field_index),
        .field_value (field_value),
        .last_field  (last_field)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic word_t open_word(int pos);
        return {open_bytes[pos], open_bytes[pos + 1]};
    endfunction

    task automatic close_frame();
        open_len = 0;
        open_sum = '0;
        open_trimmed = 0;
        open_last_cr = 1'b0;
        foreach (open_bytes[i])
            open_bytes[i] = 8'h00;
    endtask

    // Advance the mirror by one accepted byte and queue any fields it releases.
    task automatic track_rx_byte(input logic [7:0] b);
        int     pos;
        logic   was_cr;
        field_t f;
        if (open_len == 0 && b != START_BYTE)
            return;
        framed_byte_count++;
        // full buffer: frame dropped along with this byte
        if (open_len >= BUFFER_BYTES - 1)
        begin
            close_frame();
            return;
        end
        pos = open_len;
        if (pos < FRAME_MIN)
            open_bytes[pos] = b;
        if (pos < SUM_SPAN)
            open_sum = open_sum + word_t'(b);
        open_len = pos + 1;
        if (b != CR_BYTE && b != LF_BYTE)
            open_trimmed = open_len;
        was_cr = open_last_cr;
        open_last_cr = (b == CR_BYTE);
        if (b != LF_BYTE || open_len < 3 || !was_cr)
            return;
        if (open_trimmed >= FRAME_MIN && open_sum == open_word(CHK_HI_POS)
            && open_word(CO2_HI_POS) != 16'h0000)
        begin
            for (int i = 0; i < 16; i++)
            begin
                f.idx = i[3:0];
                if (f.idx == FIELD_BATT_STATUS)
                    f.value = {8'h00, open_bytes[15]};
                else if (f.idx == FIELD_BATT_LEVEL)
                    f.value = {8'h00, open_bytes[16]};
                else if (f.idx < FIELD_BATT_STATUS)
                    f.value = open_word(1 + 2 * i);
                else
                    f.value = open_word(17 + 2 * (i - 9));
                f.last = (f.idx == FIELD_LAST);
                pending_fields.push_back(f);
                field_count++;
            end
        end
        close_frame();
    endtask

    // Result side: check every field transaction, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_fields.size() == 0)
            begin
                $display("%0t: unexpected field idx %0d value %04h last %0b",
                         $time, field_index, field_value, last_field);
                error_count++;
            end
            else if (pending_fields[0] !== {field_index, field_value, last_field})
            begin
                $display("%0t: expected idx %0d value %04h last %0b, got idx %0d value %04h last %0b",
                         $time, pending_fields[0].idx, pending_fields[0].value,
                         pending_fields[0].last, field_index, field_value, last_field);
                error_count++;
                void'(pending_fields.pop_front());
            end
            else
                void'(pending_fields.pop_front());
        end
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Called at a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        track_rx_byte(b);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(9))
            0: return CR_BYTE;
            1: return LF_BYTE;
            2: return START_BYTE;
            3: return 8'h00;
            4: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Fill tx_frame with a complete frame; no CR/LF pair before the trailer.
    task automatic build_frame(input fill_e fill, input int extra, input bit bad_sum,
                               input bit zero_co2, input trail_e trail);
        word_t sum;
        bit    clean;
        do
        begin
            tx_frame.delete();
            tx_frame.push_back(START_BYTE);
            for (int i = 1; i < SUM_SPAN; i++)
                tx_frame.push_back(fill == FILL_ZERO ? 8'h00 :
                                   fill == FILL_ONES ? 8'hFF : random_byte());
            if (zero_co2)
            begin
                tx_frame[CO2_HI_POS] = 8'h00;
                tx_frame[CO2_HI_POS + 1] = 8'h00;
            end
            else if (tx_frame[CO2_HI_POS] == 8'h00 && tx_frame[CO2_HI_POS + 1] == 8'h00)
                tx_frame[CO2_HI_POS + 1] = 8'h01;
            sum = '0;
            foreach (tx_frame[i])
                sum = sum + word_t'(tx_frame[i]);
            if (bad_sum)
                sum = sum + word_t'($urandom_range(1, 65535));
            tx_frame.push_back(sum[15:8]);
            tx_frame.push_back(sum[7:0]);
            for (int i = 0; i < extra; i++)
                tx_frame.push_back(extra > 8 ? 8'($urandom_range(16, 255)) : random_byte());
            clean = !(tx_frame[$] inside {CR_BYTE, LF_BYTE});
            for (int i = 1; i < tx_frame.size(); i++)
                if (tx_frame[i - 1] == CR_BYTE && tx_frame[i] == LF_BYTE)
                    clean = 1'b0;
        end
        while (!clean);
        if (trail == TRAIL_CR_CRLF)
            tx_frame.push_back(CR_BYTE);
        else if (trail == TRAIL_LF_CRLF)
            tx_frame.push_back(LF_BYTE);
        tx_frame.push_back(CR_BYTE);
        tx_frame.push_back(LF_BYTE);
    endtask

    task automatic send_frame();
        foreach (tx_frame[i])
            send_byte(tx_frame[i]);
    endtask

    task automatic send_good_frame(input int extra);
        build_frame(FILL_RANDOM, extra, 1'b0, 1'b0, trail_e'($urandom_range(2)));
        send_frame();
    endtask

    // idle bytes; 0xAA would open a frame, so it is swapped out
    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = random_byte();
            send_byte(b == START_BYTE ? 8'h55 : b);
        end
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
    endtask

    task automatic test_idle_drop();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CR_BYTE);
        send_byte(LF_BYTE);
        send_byte(8'h55);
        send_byte(CR_BYTE);
        send_byte(LF_BYTE);
    endtask

    task automatic test_field_extremes();
        build_frame(FILL_ONES, 0, 1'b0, 1'b0, TRAIL_CRLF);
        send_frame();
        build_frame(FILL_ZERO, 0, 1'b0, 1'b0, TRAIL_CRLF);
        send_frame();
    endtask

    task automatic test_rejected_frames();
        build_frame(FILL_RANDOM, 0, 1'b1, 1'b0, TRAIL_CRLF);
        send_frame();
        build_frame(FILL_RANDOM, 1, 1'b0, 1'b1, TRAIL_CRLF);
        send_frame();
        // closes with a short trimmed length
        send_byte(START_BYTE);
        send_byte(8'h11);
        send_byte(CR_BYTE);
        send_byte(LF_BYTE);
        send_good_frame(0);
    endtask

    task automatic test_early_lf();
        // LF at the second position and LF without CR are plain data
        send_byte(START_BYTE);
        send_byte(LF_BYTE);
        send_byte(START_BYTE);
        send_byte(LF_BYTE);
        send_byte(CR_BYTE);
        send_byte(LF_BYTE);
        send_good_frame(0);
    endtask

    task automatic test_trailing_trim();
        build_frame(FILL_RANDOM, 3, 1'b0, 1'b0, TRAIL_LF_CRLF);
        send_frame();
        build_frame(FILL_RANDOM, 0, 1'b0, 1'b0, TRAIL_CR_CRLF);
        send_frame();
    endtask

    task automatic test_overflow();
        send_byte(START_BYTE);
        repeat (BUFFER_BYTES - 2)
            send_byte(8'($urandom_range(16, 255)));
        // buffer full: this start byte goes with the dropped frame
        send_byte(START_BYTE);
        send_good_frame(1);
    endtask

    task automatic test_longest_frame();
        // CR LF lands on the last slot before overflow
        build_frame(FILL_RANDOM, BUFFER_BYTES - FRAME_MIN - 3, 1'b0, 1'b0, TRAIL_CRLF);
        send_frame();
    endtask

    task automatic test_drain_pause();
        send_good_frame(2);
        wait_drained();
        send_good_frame(0);
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int start_fields;
        int cut;
        bit bad_sum;
        start_bytes = framed_byte_count;
        start_fields = field_count;
        while (framed_byte_count - start_bytes < 40 || field_count - start_fields < 16)
        begin
            case ($urandom_range(9))
                6: send_noise($urandom_range(1, 6));
                7:
                begin
                    bad_sum = $urandom_range(1);
                    build_frame(FILL_RANDOM, $urandom_range(3), bad_sum, !bad_sum,
                                trail_e'($urandom_range(2)));
                    send_frame();
                end
                8:
                begin
                    // frame broken off early
                    build_frame(FILL_RANDOM, 0, 1'b0, 1'b0, TRAIL_CRLF);
                    cut = $urandom_range(1, tx_frame.size() - 3);
                    for (int i = 0; i < cut; i++)
                        send_byte(tx_frame[i]);
                    send_byte(CR_BYTE);
                    send_byte(LF_BYTE);
                end
                9: wait_drained();
                default:
                    send_good_frame($urandom_range(7) == 0 ? $urandom_range(60)
                                                           : $urandom_range(3));
            endcase
        end
    endtask

    initial
    begin
        close_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(13, 82);
        test_idle_drop();
        test_field_extremes();
        test_rejected_frames();
        test_early_lf();
        test_trailing_trim();
        test_overflow();
        test_longest_frame();
        test_drain_pause();
        test_random_traffic();

        set_idling(82, 13);
        test_random_traffic();

        set_idling(0, 0);
        test_random_traffic();

        wait_drained();
        if (error_count == 0 && pending_fields.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
src/sfr_pkg.sv
src/sensor_frame_receiver_unit.sv
src/sfr_checker.sv
tb/sv/sensor_frame_receiver_unit_test.sv
